// File: hw/rtl/serial_frame_receiver_xor_top_macros.svh
// Assertion macros for the serial frame receiver.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef SERIAL_FRAME_RECEIVER_XOR_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_XOR_TOP_MACROS_SVH

// Check that ante implies cons in the same cycle, outside reset.
`define SFRX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds, outside reset.
`define SFRX_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/sfrx_pkg.sv
// Shared types and constants for the serial frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfrx_pkg;

  // Default largest payload length.
  localparam int MAX_PAYLOAD_DEF = 32;
  // Length field width in the frame descriptor, covers lengths up to 127.
  localparam int LEN_FIELD_W = 7;
  // Descriptor queue depth; equals the number of frame buffers in the store.
  localparam int DESC_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_HEADER = 3'd0;
  localparam logic [2:0] REG_NOACK_A = 3'd1;
  localparam logic [2:0] REG_NOACK_B = 3'd2;
  localparam logic [2:0] REG_NOACK_C = 3'd3;
  localparam logic [2:0] REG_NOACK_D = 3'd4;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_CMD     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // One checked frame waiting for release.
  typedef struct packed {
    logic [7:0]             cmd;
    logic [LEN_FIELD_W-1:0] len;
    logic                   ack;
    logic                   bank;
  } desc_t;

endpackage
`default_nettype wire

// File: hw/rtl/sfrx_desc_fifo.sv
// Two-entry queue of checked frame descriptors between parser and release.
// Depends on sfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfrx_desc_fifo (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  sfrx_pkg::desc_t din,
  input  wire            pop,
  output sfrx_pkg::desc_t dout,
  output logic           valid,
  output logic           full
);
  import sfrx_pkg::*;

  desc_t      entries [DESC_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign dout  = entries[rptr];
  assign valid = (count != 2'd0);
  assign full  = (count == 2'(DESC_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sfrx_front.sv
// Frame parser: hunts for the header, checks length and checksum, writes
// payload into the store and queues a descriptor per good frame. Uses sfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfrx_front #(
  parameter int MAX_PAYLOAD = sfrx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  cfg_we,
  input  wire  [2:0] cfg_index,
  input  wire  [7:0] cfg_data,
  input  wire  push,
  input  wire  full,
  input  wire  [7:0] rx_byte,
  output logic wr_en,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] wr_addr,
  output logic [7:0] wr_data,
  output logic desc_push,
  output sfrx_pkg::desc_t desc
);
  import sfrx_pkg::*;

  localparam int LenW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxLenByte = 8'(MAX_PAYLOAD);

  logic [7:0]      header_byte;
  logic [7:0]      noack_a;
  logic [7:0]      noack_b;
  logic [7:0]      noack_c;
  logic [7:0]      noack_d;

  phase_t          phase;
  phase_t          phase_next;
  logic [LenW-1:0] expected_len;
  logic [LenW-1:0] payload_count;
  logic [LenW-1:0] count_inc;
  logic [7:0]      held_cmd;
  logic [7:0]      running_xor;
  logic            wbank;
  logic            fire;
  logic            sum_ok;
  logic            ack;

  assign fire      = push && !full;
  assign count_inc = payload_count + LenW'(1);
  assign sum_ok    = (rx_byte == running_xor);
  assign ack       = !((held_cmd == noack_a) || (held_cmd == noack_b) ||
                       (held_cmd == noack_c) || (held_cmd == noack_d));

  // Next phase
  always_comb begin
    phase_next = phase;
    if (fire) begin
      case (phase)
        PH_LEN: begin
          phase_next = (rx_byte > MaxLenByte) ? PH_HUNT : PH_CMD;
        end
        PH_CMD: begin
          phase_next = (expected_len == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          phase_next = (count_inc == expected_len) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_CHECK: begin
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = (rx_byte == header_byte) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  // Store write and descriptor push
  always_comb begin
    wr_en     = fire && (phase == PH_PAYLOAD);
    wr_addr   = {wbank, payload_count[AW-1:0]};
    wr_data   = rx_byte;
    desc_push = fire && (phase == PH_CHECK) && sum_ok;
    desc.cmd  = held_cmd;
    desc.len  = LEN_FIELD_W'(expected_len);
    desc.ack  = ack;
    desc.bank = wbank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'hAA;
      noack_a     <= 8'h00;
      noack_b     <= 8'h00;
      noack_c     <= 8'h00;
      noack_d     <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER:  header_byte <= cfg_data;
        REG_NOACK_A: noack_a     <= cfg_data;
        REG_NOACK_B: noack_b     <= cfg_data;
        REG_NOACK_C: noack_c     <= cfg_data;
        REG_NOACK_D: noack_d     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      expected_len  <= '0;
      payload_count <= '0;
      held_cmd      <= 8'h00;
      running_xor   <= 8'h00;
      wbank         <= 1'b0;
    end else begin
      phase <= phase_next;
      if (fire) begin
        case (phase)
          PH_LEN: begin
            if (rx_byte <= MaxLenByte) begin
              expected_len <= rx_byte[LenW-1:0];
              running_xor  <= running_xor ^ rx_byte;
            end
          end
          PH_CMD: begin
            held_cmd      <= rx_byte;
            running_xor   <= running_xor ^ rx_byte;
            payload_count <= '0;
          end
          PH_PAYLOAD: begin
            payload_count <= count_inc;
            running_xor   <= running_xor ^ rx_byte;
          end
          PH_CHECK: begin
            // a good frame owns this bank until released
            if (sum_ok) begin
              wbank <= ~wbank;
            end
          end
          default: begin
            if (rx_byte == header_byte) begin
              running_xor <= 8'h00;
            end
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sfrx_back.sv
// Frame release: holds the two-bank payload store and walks each queued frame out
// one result per cycle, while pop keeps up, into the output register. Uses sfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfrx_back #(
  parameter int MAX_PAYLOAD = sfrx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  wr_en,
  input  wire  [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] wr_addr,
  input  wire  [7:0] wr_data,
  input  sfrx_pkg::desc_t head,
  input  wire  head_valid,
  output logic head_pop,
  input  wire  pop,
  output logic empty,
  output logic [7:0] frame_cmd,
  output logic [5:0] frame_len,
  output logic has_payload,
  output logic [4:0] byte_index,
  output logic [7:0] payload_byte,
  output logic last_of_frame,
  output logic send_ack
);
  import sfrx_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int Depth = 2 ** (AW + 1);

  logic [7:0]             mem [Depth];
  logic [7:0]             rd_data;
  logic [AW-1:0]          idx;
  logic [LEN_FIELD_W-1:0] idx_ext;
  logic                   out_valid;
  logic                   rd_en;
  logic                   is_last;

  assign idx_ext  = LEN_FIELD_W'(idx);
  assign is_last  = (head.len == '0) || ((idx_ext + LEN_FIELD_W'(1)) == head.len);
  assign rd_en    = head_valid && (!out_valid || pop);
  assign head_pop = rd_en && is_last;
  assign empty    = !out_valid;
  assign payload_byte = has_payload ? rd_data : 8'h00;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data       <= mem[{head.bank, idx}];
      frame_cmd     <= head.cmd;
      frame_len     <= head.len[5:0];
      has_payload   <= (head.len != '0);
      byte_index    <= idx_ext[4:0];
      last_of_frame <= is_last;
      send_ack      <= head.ack;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (rd_en) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + AW'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/serial_frame_receiver_xor_top.sv
// Top level of the serial frame receiver with XOR checksum.
// Depends on sfrx_pkg, sfrx_front, sfrx_desc_fifo, sfrx_back and the macro header.
`timescale 1ns / 1ps
`default_nettype none
// Receives one serial byte per transfer and recognizes frames of the form
// header, length, command, payload, checksum, where the checksum is the XOR of
// length, command and payload. Each good frame is released as one result per
// payload byte (a single result with has_payload low for a zero-length frame);
// frames with a bad checksum or an oversize length give nothing. Input: one
// byte is taken per cycle in which push is high and full is low. Output: a frame
// is released one result per cycle while pop keeps taking them, from the single
// store read port; the first result passes through the descriptor queue and then
// the output register after the checksum byte is taken. The store holds two frame
// buffers, so full rises while two checked frames still wait for release and
// falls once the older one has left. There is no clearing pass after reset.
// Configuration: write register cfg_index with cfg_data while cfg_we is high;
// 0 header byte, 1..4 the command codes that get no acknowledge.
module serial_frame_receiver_xor_top #(
  parameter int MAX_PAYLOAD = sfrx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire  [2:0] cfg_index,
  input  wire  [7:0] cfg_data,
  input  wire        push,
  output logic       full,
  input  wire  [7:0] rx_byte,
  input  wire        pop,
  output logic       empty,
  output logic [7:0] frame_cmd,
  output logic [5:0] frame_len,
  output logic       has_payload,
  output logic [4:0] byte_index,
  output logic [7:0] payload_byte,
  output logic       last_of_frame,
  output logic       send_ack
);
  import sfrx_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic          desc_push;
  desc_t         desc_in;
  desc_t         head;
  logic          head_valid;
  logic          head_pop;
  logic          empty_shape_ok;

  // Front: parse bytes, fill the store, queue good frames.
  sfrx_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .desc_push (desc_push),
    .desc      (desc_in)
  );

  // Queue: one entry per store bank; full holds the input side.
  sfrx_desc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .din   (desc_in),
    .pop   (head_pop),
    .dout  (head),
    .valid (head_valid),
    .full  (full)
  );

  // Back: drain the head frame into the output register.
  sfrx_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .head          (head),
    .head_valid    (head_valid),
    .head_pop      (head_pop),
    .pop           (pop),
    .empty         (empty),
    .frame_cmd     (frame_cmd),
    .frame_len     (frame_len),
    .has_payload   (has_payload),
    .byte_index    (byte_index),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame),
    .send_ack      (send_ack)
  );

  // Checks
  assign empty_shape_ok = (frame_len == 6'd0) && last_of_frame && (byte_index == 5'd0);

`include "serial_frame_receiver_xor_top_macros.svh"

  `SFRX_ASSERT_IMP(a_store_write_on_transfer, wr_en, push && !full, "write without transfer")
  `SFRX_ASSERT_NEVER(a_no_push_when_full, desc_push && full, "descriptor pushed into full queue")
  `SFRX_ASSERT_IMP(a_empty_shape, !empty && !has_payload, empty_shape_ok, "bad empty frame")
  `SFRX_ASSERT_NEVER(a_no_pop_empty_queue, head_pop && !head_valid, "release of missing frame")

endmodule
`default_nettype wire

// File: verif/serial_frame_receiver_xor_top_test.sv
// Self-checking test of serial_frame_receiver_xor_top: framed, noisy and broken byte
// streams with random gaps, checked against a frame parser model kept in a scoreboard.
// Depends on sfrx_pkg and the serial_frame_receiver_xor_top RTL only.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] cmd;
  logic [5:0] len;
  logic       has_payload;
  logic [4:0] idx;
  logic [7:0] data;
  logic       last;
  logic       ack;
} frame_result_t;

class frame_scoreboard;
  logic [7:0] header_val;
  logic [7:0] noack_codes[4];
  sfrx_pkg::phase_t ph;
  logic [5:0] want_len;
  logic [7:0] cmd_hold;
  logic [5:0] pay_cnt;
  logic [7:0] xor_acc;
  logic [7:0] pay_mem[32];
  frame_result_t expected_results[$];
  int mismatches;

  function new();
    header_val = 8'hAA;
    foreach (noack_codes[i]) noack_codes[i] = 8'h00;
    ph = sfrx_pkg::PH_HUNT;
    want_len = '0;
    cmd_hold = '0;
    pay_cnt = '0;
    xor_acc = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      sfrx_pkg::REG_HEADER: header_val = val;
      sfrx_pkg::REG_NOACK_A: noack_codes[0] = val;
      sfrx_pkg::REG_NOACK_B: noack_codes[1] = val;
      sfrx_pkg::REG_NOACK_C: noack_codes[2] = val;
      sfrx_pkg::REG_NOACK_D: noack_codes[3] = val;
      default: ;
    endcase
  endfunction

  // Advance the parser by one accepted byte; queue the results of a good frame.
  function void note_rx_byte(logic [7:0] b);
    frame_result_t r;
    case (ph)
      sfrx_pkg::PH_LEN: begin
        if (b > sfrx_pkg::MAX_PAYLOAD_DEF) begin
          ph = sfrx_pkg::PH_HUNT;
        end else begin
          want_len = b[5:0];
          xor_acc ^= b;
          ph = sfrx_pkg::PH_CMD;
        end
      end
      sfrx_pkg::PH_CMD: begin
        cmd_hold = b;
        xor_acc ^= b;
        pay_cnt = '0;
        ph = (want_len == 0) ? sfrx_pkg::PH_CHECK : sfrx_pkg::PH_PAYLOAD;
      end
      sfrx_pkg::PH_PAYLOAD: begin
        pay_mem[pay_cnt[4:0]] = b;
        pay_cnt = pay_cnt + 6'd1;
        xor_acc ^= b;
        if (pay_cnt >= want_len) ph = sfrx_pkg::PH_CHECK;
      end
      sfrx_pkg::PH_CHECK: begin
        if (b == xor_acc) begin
          r.cmd = cmd_hold;
          r.len = want_len;
          r.ack = (cmd_hold != noack_codes[0]) && (cmd_hold != noack_codes[1]) &&
                  (cmd_hold != noack_codes[2]) && (cmd_hold != noack_codes[3]);
          if (want_len == 0) begin
            r.has_payload = 1'b0;
            r.idx = '0;
            r.data = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
          end else begin
            for (int i = 0; i < want_len; i++) begin
              r.has_payload = 1'b1;
              r.idx = 5'(i);
              r.data = pay_mem[i];
              r.last = (i == want_len - 1);
              expected_results.push_back(r);
            end
          end
        end
        ph = sfrx_pkg::PH_HUNT;
      end
      default: begin
        ph = sfrx_pkg::PH_HUNT;
        if (b == header_val) begin
          xor_acc = '0;
          ph = sfrx_pkg::PH_LEN;
        end
      end
    endcase
  endfunction

  task report(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task compare_field(string name, int unsigned got_v, int unsigned want_v);
    if (got_v != want_v)
      report($sformatf("%s mismatch: got %0d, want %0d", name, got_v, want_v));
  endtask

  task check_result(frame_result_t got);
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result cmd %0d idx %0d", got.cmd, got.idx));
    end else begin
      want = expected_results.pop_front();
      compare_field("frame_cmd", got.cmd, want.cmd);
      compare_field("frame_len", got.len, want.len);
      compare_field("has_payload", got.has_payload, want.has_payload);
      compare_field("byte_index", got.idx, want.idx);
      compare_field("payload_byte", got.data, want.data);
      compare_field("last_of_frame", got.last, want.last);
      compare_field("send_ack", got.ack, want.ack);
    end
  endtask
endclass

module serial_frame_receiver_xor_top_test;
  localparam int MAX_LEN = sfrx_pkg::MAX_PAYLOAD_DEF;
  // Cycles to let the block settle once the last expected result is out.
  localparam int QUIET_CYCLES = 4;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       push = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] frame_cmd;
  logic [5:0] frame_len;
  logic       has_payload;
  logic [4:0] byte_index;
  logic [7:0] payload_byte;
  logic       last_of_frame;
  logic       send_ack;

  frame_scoreboard sb = new();

  // Current settings as seen by the stimulus, so frames use the live header.
  logic [7:0] header_now = 8'hAA;
  logic [7:0] noack_now[4] = '{8'h00, 8'h00, 8'h00, 8'h00};

  // When set, the side in question runs back to back with no idle cycles.
  bit send_burst = 1'b0;
  bit pop_burst = 1'b0;

  serial_frame_receiver_xor_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .pop          (pop),
    .empty        (empty),
    .frame_cmd    (frame_cmd),
    .frame_len    (frame_len),
    .has_payload  (has_payload),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .last_of_frame(last_of_frame),
    .send_ack     (send_ack)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop. The slowest legal run stays far below this.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Push one byte. Idle a random number of cycles first, then hold push until
  // the transfer happens. Leave push high so a following zero-gap byte does
  // not toggle it within the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    sb.note_rx_byte(b);
  endtask

  // Send header, length, command, random payload and checksum; corrupt the
  // checksum on request.
  task automatic send_frame(input int len, input logic [7:0] cmd, input bit corrupt);
    logic [7:0] chk;
    logic [7:0] b;
    chk = 8'(len) ^ cmd;
    send_byte(header_now);
    send_byte(8'(len));
    send_byte(cmd);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      chk ^= b;
      send_byte(b);
    end
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // Stop sending and wait until every expected result has been popped, then
  // let the block settle and finish whatever it holds.
  task automatic hold_until_drained();
    push <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write every register index, including the unused ones, with the block idle.
  task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] na,
                                input logic [7:0] nb, input logic [7:0] nc,
                                input logic [7:0] nd);
    logic [7:0] vals[1 << $bits(cfg_index)];
    foreach (vals[i]) vals[i] = 8'($urandom);
    vals[sfrx_pkg::REG_HEADER] = hdr;
    vals[sfrx_pkg::REG_NOACK_A] = na;
    vals[sfrx_pkg::REG_NOACK_B] = nb;
    vals[sfrx_pkg::REG_NOACK_C] = nc;
    vals[sfrx_pkg::REG_NOACK_D] = nd;
    hold_until_drained();
    foreach (vals[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    header_now = hdr;
    noack_now = '{na, nb, nc, nd};
  endtask

  // Mostly good frames with random content; the rest bad checksums, oversize
  // lengths, cut-off frames and line noise. Open with a full-size frame.
  task automatic run_random(input int target);
    int sent;
    int pick;
    int len;
    int cut;
    bit first;
    bit held;
    logic [7:0] cmd;
    sent = 0;
    first = 1'b1;
    held = 1'b0;
    while (sent < target) begin
      send_burst = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (first) len = MAX_LEN;
      else begin
        case ($urandom_range(0, 19))
          0: len = MAX_LEN;
          1: len = 0;
          2, 3, 4: len = $urandom_range(9, MAX_LEN - 1);
          default: len = $urandom_range(1, 8);
        endcase
      end
      cmd = ($urandom_range(0, 3) == 0) ? noack_now[$urandom_range(0, 3)] : 8'($urandom);
      if (first || pick < 72) begin
        send_frame(len, cmd, 1'b0);
        sent += len + 4;
      end else if (pick < 82) begin
        send_frame(len, cmd, 1'b1);
        sent += len + 4;
      end else if (pick < 89) begin
        send_byte(header_now);
        send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
        sent += 2;
      end else if (pick < 95) begin
        // noise on the line; mostly ignored while hunting
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        // drop the tail of a frame; what follows lands in its payload
        len = $urandom_range(1, MAX_LEN);
        cut = $urandom_range(0, len - 1);
        send_byte(header_now);
        send_byte(8'(len));
        send_byte(cmd);
        repeat (cut) send_byte(8'($urandom));
        sent += cut + 3;
      end
      first = 1'b0;
      // Once per phase, let the output side drain completely mid-stream.
      if (!held && sent >= target / 2) begin
        hold_until_drained();
        held = 1'b1;
      end
    end
  endtask

  // Result side: stall a random number of cycles before each transfer, with
  // occasional stretches of back-to-back pops, and check every result taken.
  initial begin
    int stall;
    frame_result_t got;
    while (rst) @(posedge clk);
    forever begin
      stall = pop_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      got.cmd = frame_cmd;
      got.len = frame_len;
      got.has_payload = has_payload;
      got.idx = byte_index;
      got.data = payload_byte;
      got.last = last_of_frame;
      got.ack = send_ack;
      sb.check_result(got);
      if ($urandom_range(0, 24) == 0) pop_burst = !pop_burst;
    end
  end

  // Stimulus: reset, a directed pass at reset settings, then random phases
  // under several register settings, extremes included.
  initial begin
    logic [7:0] directed[] = '{
      8'h55, 8'h00,                      // noise while hunting
      8'hAA, 8'h00, 8'h00, 8'h00,        // zero-length frame, command hits no-ack
      8'hAA, 8'h01, 8'hFF, 8'hFF, 8'h01, // one byte, all ones
      8'hAA, 8'h21,                      // length just above the limit
      8'hAA, 8'hFF,                      // largest length byte
      8'hAA, 8'h00, 8'h12, 8'h00,        // bad checksum
      8'hAA, 8'h02, 8'h80, 8'h00, 8'hAA, 8'h28 // header value inside payload
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);

    apply_settings(8'h00, 8'hFF, 8'h00, 8'h7E, 8'h81);
    run_random(40);
    apply_settings(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF);
    run_random(40);
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
    run_random(40);
    apply_settings(8'hAA, 8'h01, 8'h02, 8'h03, 8'h04);
    run_random(40);

    // Drain, then allow time for any stray result to show up.
    hold_until_drained();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
